/* design/lwa_pkg.sv */
// lwa_pkg: shared constants, command codes, state type and the control and
// status structs used between the controller and the datapath.
// no dependencies.
`default_nettype none

package lwa_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_LENGTH  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_LENGTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DIM_W   = 7;    // grid size registers
  localparam int COORD_W = 6;    // x_pos, y_pos, window_radius
  localparam int SAMP_W  = 16;   // amplitudes, scale factor, average
  localparam int CNT_W   = ADDR_W + 1;          // entry count up to STORE_DEPTH
  localparam int SUM_W   = SAMP_W + ADDR_W;     // window sum incl. sign
  localparam int PROD_W  = 2 * SAMP_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int FRAC_BITS = 8;

  localparam int REG_IDX_W  = 2;
  localparam int CMD_W      = 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GRID_LENGTH = REG_IDX_W'(1);

  localparam logic signed [SAMP_W-1:0] SCALE_ONE = SAMP_W'(256);

  typedef enum logic [CMD_W-1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_SCALE = 2'd2,
    OP_NOP   = 2'd3
  } lwa_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCL_RD,
    ST_SCL_MUL,
    ST_SCL_WR,
    ST_Q_BASE,
    ST_Q_WALK,
    ST_Q_DRAIN,
    ST_Q_DIV_INIT,
    ST_Q_DIV,
    ST_DONE
  } lwa_state_t;

  typedef struct packed {
    logic cap_item;
    logic do_write;
    logic scl_rd;
    logic scl_mul;
    logic scl_wr;
    logic q_setup;
    logic walk_start;
    logic walk_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } lwa_ctl_t;

  typedef struct packed {
    lwa_op_t op;
    logic    scale_skip;
    logic    q_empty;
    logic    scl_last;
    logic    walk_last;
    logic    div_done;
    logic    out_busy;
  } lwa_sts_t;

endpackage

`default_nettype wire

/* design/lwa_in_if.sv */
// lwa_in_if: command channel with valid/ready handshake and item payload.
// depends on lwa_pkg.
`default_nettype none

interface lwa_in_if
  import lwa_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [COORD_W-1:0]        x_pos;
  logic [COORD_W-1:0]        y_pos;
  logic [COORD_W-1:0]        window_radius;
  logic signed [SAMP_W-1:0]  sample_value;
  logic signed [SAMP_W-1:0]  scale_factor;

  modport source (output valid, cmd, x_pos, y_pos, window_radius, sample_value,
                  scale_factor, input ready);
  modport sink   (input valid, cmd, x_pos, y_pos, window_radius, sample_value,
                  scale_factor, output ready);
endinterface

`default_nettype wire

/* design/lwa_out_if.sv */
// lwa_out_if: result channel with valid/ready handshake and query result.
// depends on lwa_pkg.
`default_nettype none

interface lwa_out_if
  import lwa_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SAMP_W-1:0]  average;
  logic                      window_empty;

  modport source (output valid, average, window_empty, input ready);
  modport sink   (input valid, average, window_empty, output ready);
endinterface

`default_nettype wire

/* design/lwa_cfg_if.sv */
// lwa_cfg_if: configuration write channel, register index and write data.
// depends on lwa_pkg.
`default_nettype none

interface lwa_cfg_if
  import lwa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [DIM_W-1:0]      wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* design/lwa_ctrl.sv */
// lwa_ctrl: command sequencer for write, scale and window query.
// depends on lwa_pkg; drives the datapath through lwa_ctl_t.
`default_nettype none

module lwa_ctrl
  import lwa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lwa_sts_t sts,
  output lwa_ctl_t      ctl
);

  lwa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_QUERY: state_nxt = ST_Q_BASE;
          OP_SCALE: state_nxt = sts.scale_skip ? ST_IDLE : ST_SCL_RD;
          OP_WRITE: state_nxt = ST_IDLE;
          OP_NOP:   state_nxt = ST_IDLE;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_SCL_RD:     state_nxt = ST_SCL_MUL;
      ST_SCL_MUL:    state_nxt = ST_SCL_WR;
      ST_SCL_WR:     state_nxt = sts.scl_last ? ST_IDLE : ST_SCL_RD;
      ST_Q_BASE:     state_nxt = sts.q_empty ? ST_DONE : ST_Q_WALK;
      ST_Q_WALK: begin
        if (sts.walk_last) state_nxt = ST_Q_DRAIN;
      end
      ST_Q_DRAIN:    state_nxt = ST_Q_DIV_INIT;
      ST_Q_DIV_INIT: state_nxt = ST_Q_DIV;
      ST_Q_DIV: begin
        if (sts.div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctl.cap_item = in_valid;
      end
      ST_DECODE: begin
        ctl.do_write = (sts.op == OP_WRITE);
        ctl.q_setup  = (sts.op == OP_QUERY);
      end
      ST_SCL_RD:     ctl.scl_rd = 1'b1;
      ST_SCL_MUL:    ctl.scl_mul = 1'b1;
      ST_SCL_WR:     ctl.scl_wr = 1'b1;
      ST_Q_BASE:     ctl.walk_start = ~sts.q_empty;
      ST_Q_WALK:     ctl.walk_step = 1'b1;
      ST_Q_DRAIN:    ctl = '0;
      ST_Q_DIV_INIT: ctl.div_start = 1'b1;
      ST_Q_DIV:      ctl.div_step = 1'b1;
      ST_DONE:       ctl.load_out = ~sts.out_busy;
      default:       ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/lwa_dp.sv */
// lwa_dp: amplitude store, config registers, window walk, scaler, divider
// and result register. depends on lwa_pkg; commanded by lwa_ctrl.
`default_nettype none

module lwa_dp
  import lwa_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [REG_IDX_W-1:0]      cfg_index,
  input  wire logic [DIM_W-1:0]          cfg_data,
  // item payload
  input  wire logic [CMD_W-1:0]          in_cmd,
  input  wire logic [COORD_W-1:0]        in_x_pos,
  input  wire logic [COORD_W-1:0]        in_y_pos,
  input  wire logic [COORD_W-1:0]        in_window_radius,
  input  wire logic signed [SAMP_W-1:0]  in_sample_value,
  input  wire logic signed [SAMP_W-1:0]  in_scale_factor,
  // result
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [SAMP_W-1:0]       out_average,
  output logic                           out_window_empty,
  // control
  input  wire lwa_ctl_t                  ctl,
  output lwa_sts_t                       sts
);

  // config registers
  logic [DIM_W-1:0] grid_width_r, grid_length_r;
  logic [DIM_W-1:0] w_eff, len_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= '0;
      grid_length_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r <= cfg_data;
        REG_GRID_LENGTH: grid_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff   = (grid_width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width_r;
  assign len_eff = (grid_length_r > DIM_W'(MAX_LENGTH)) ? DIM_W'(MAX_LENGTH) : grid_length_r;

  // captured item
  logic [CMD_W-1:0]         cmd_r;
  logic [COORD_W-1:0]       x_r, y_r, rad_r;
  logic signed [SAMP_W-1:0] sample_r, factor_r;
  logic [CNT_W-1:0]         n_r;
  logic [2*DIM_W-1:0]       n_full;

  assign n_full = w_eff * len_eff;

  always_ff @(posedge clk) begin
    if (ctl.cap_item) begin
      cmd_r    <= in_cmd;
      x_r      <= in_x_pos;
      y_r      <= in_y_pos;
      rad_r    <= in_window_radius;
      sample_r <= in_sample_value;
      factor_r <= in_scale_factor;
      n_r      <= n_full[CNT_W-1:0];
    end
  end

  // amplitude store
  logic signed [SAMP_W-1:0] store [STORE_DEPTH];
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic signed [SAMP_W-1:0] mem_wdata;
  logic signed [SAMP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= store[mem_raddr];
  end

  // sample write
  logic                 in_grid;
  logic [2*DIM_W-1:0]   wr_prod;
  logic [ADDR_W-1:0]    wr_addr;

  assign in_grid = ({1'b0, x_r} < w_eff) && ({1'b0, y_r} < len_eff);
  assign wr_prod = {1'b0, x_r} * len_eff;
  assign wr_addr = wr_prod[ADDR_W-1:0] + ADDR_W'(y_r);

  // scale pass
  logic [ADDR_W-1:0]          scl_idx_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-FRAC_BITS-1:0] shifted;
  logic signed [SAMP_W-1:0]   scaled;

  always_ff @(posedge clk) begin
    if (ctl.cap_item) begin
      scl_idx_r <= '0;
    end else if (ctl.scl_wr) begin
      scl_idx_r <= scl_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scl_mul) prod_r <= rdata_r * factor_r;
  end

  // arithmetic shift by taking the upper bits: floor division
  assign shifted = prod_r[PROD_W-1:FRAC_BITS];

  always_comb begin
    priority if (shifted > (PROD_W-FRAC_BITS)'(signed'(SAMP_W'(16'sh7fff)))) begin
      scaled = 16'sh7fff;
    end else if (shifted < -(PROD_W-FRAC_BITS)'(2 ** (SAMP_W-1))) begin
      scaled = 16'sh8000;
    end else begin
      scaled = shifted[SAMP_W-1:0];
    end
  end

  // window bounds
  logic signed [COORD_W+1:0] x_dif, y_dif;
  logic [COORD_W:0]          x_sum, y_sum, x_hi7, y_hi7, w_m1, l_m1;
  logic [COORD_W-1:0]        x_lo, y_lo;
  logic                      empty_c;
  logic [COORD_W-1:0]        lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic                      empty_r;

  assign x_dif = $signed({2'b00, x_r}) - $signed({2'b00, rad_r});
  assign y_dif = $signed({2'b00, y_r}) - $signed({2'b00, rad_r});
  assign x_lo  = x_dif[COORD_W+1] ? '0 : x_dif[COORD_W-1:0];
  assign y_lo  = y_dif[COORD_W+1] ? '0 : y_dif[COORD_W-1:0];
  assign x_sum = {1'b0, x_r} + {1'b0, rad_r};
  assign y_sum = {1'b0, y_r} + {1'b0, rad_r};
  assign w_m1  = w_eff - 1'b1;
  assign l_m1  = len_eff - 1'b1;
  assign x_hi7 = (x_sum > w_m1) ? w_m1 : x_sum;
  assign y_hi7 = (y_sum > l_m1) ? l_m1 : y_sum;
  assign empty_c = (w_eff == '0) || (len_eff == '0) ||
                   ({1'b0, x_lo} > x_hi7) || ({1'b0, y_lo} > y_hi7);

  always_ff @(posedge clk) begin
    if (ctl.q_setup) begin
      lo_x_r  <= x_lo;
      lo_y_r  <= y_lo;
      hi_x_r  <= x_hi7[COORD_W-1:0];
      hi_y_r  <= y_hi7[COORD_W-1:0];
      empty_r <= empty_c;
    end
  end

  // window walk and sum
  logic [COORD_W-1:0]     i_r, j_r;
  logic [ADDR_W-1:0]      row_base_r;
  logic [ADDR_W-1:0]      walk_addr;
  logic [2*DIM_W-1:0]     base_prod, cnt_prod;
  logic [COORD_W:0]       span_x, span_y;
  logic [CNT_W-1:0]       count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                   rd_pend_r;
  logic                   walk_last;

  assign base_prod = {1'b0, lo_x_r} * len_eff;
  assign span_x    = {1'b0, hi_x_r} - {1'b0, lo_x_r} + 1'b1;
  assign span_y    = {1'b0, hi_y_r} - {1'b0, lo_y_r} + 1'b1;
  assign cnt_prod  = span_x * span_y;
  assign walk_addr = row_base_r + ADDR_W'(j_r);
  assign walk_last = (i_r == hi_x_r) && (j_r == hi_y_r);

  always_ff @(posedge clk) begin
    if (ctl.walk_start) begin
      i_r        <= lo_x_r;
      j_r        <= lo_y_r;
      row_base_r <= base_prod[ADDR_W-1:0];
      count_r    <= cnt_prod[CNT_W-1:0];
    end else if (ctl.walk_step) begin
      if (j_r == hi_y_r) begin
        j_r        <= lo_y_r;
        i_r        <= i_r + 1'b1;
        row_base_r <= row_base_r + ADDR_W'(len_eff);
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= ctl.walk_step;
    end
  end

  // read data lands in the cycle after each walk step
  always_ff @(posedge clk) begin
    if (ctl.walk_start) begin
      sum_r <= '0;
    end else if (rd_pend_r) begin
      sum_r <= sum_r + {{(SUM_W-SAMP_W){rdata_r[SAMP_W-1]}}, rdata_r};
    end
  end

  // memory port selection
  assign mem_re    = ctl.scl_rd | ctl.walk_step;
  assign mem_raddr = ctl.walk_step ? walk_addr : scl_idx_r;
  assign mem_we    = (ctl.do_write & in_grid) | ctl.scl_wr;
  assign mem_waddr = ctl.scl_wr ? scl_idx_r : wr_addr;
  assign mem_wdata = ctl.scl_wr ? scaled : sample_r;

  // restoring divider on the magnitude, one quotient bit per cycle
  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W:0]       rem_r;
  logic [CNT_W:0]       rem_sh;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 neg_r;

  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg_r     <= sum_r[SUM_W-1];
      quo_r     <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (ctl.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (rem_sh >= {1'b0, count_r}) begin
        rem_r <= rem_sh - {1'b0, count_r};
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  // result register
  logic                     out_valid_r;
  logic signed [SAMP_W-1:0] out_avg_r;
  logic                     out_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_empty_r <= empty_r;
      if (empty_r) begin
        out_avg_r <= '0;
      end else if (neg_r) begin
        out_avg_r <= -$signed(quo_r[SAMP_W-1:0]);
      end else begin
        out_avg_r <= $signed(quo_r[SAMP_W-1:0]);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average      = out_avg_r;
  assign out_window_empty = out_empty_r;

  // status
  assign sts.op         = lwa_op_t'(cmd_r);
  assign sts.scale_skip = (factor_r == SCALE_ONE) || (n_r == '0);
  assign sts.q_empty    = empty_r;
  assign sts.scl_last   = ({1'b0, scl_idx_r} == (n_r - 1'b1));
  assign sts.walk_last  = walk_last;
  assign sts.div_done   = (div_cnt_r == DIV_CNT_W'(SUM_W - 1));
  assign sts.out_busy   = out_valid_r & ~out_ready;

endmodule

`default_nettype wire

/* design/lattice_window_average.sv */
// lattice_window_average: top level, grid store with write, scale and
// edge-clamped window average. depends on lwa_pkg, the lwa_*_if
// interfaces, lwa_ctrl and lwa_dp.
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   cmd, x_pos, y_pos, window_radius,
//                                sample_value, scale_factor
//   out_ch    out  valid/ready   average, window_empty (queries only)
//   cfg_ch    in   valid/ready   reg_index, wdata (grid_width, grid_length)
//
// one transaction at a time: a scale reads, multiplies and writes back each
// entry in turn, and a query walks the window over the single memory read
// port, then runs the 28-step divider.
// rst_n is synchronous; the store contents are not cleared.
// a finished query result waits in the output register; the next command is
// taken meanwhile and only a following result stalls on a busy output.
`default_nettype none

module lattice_window_average
  import lwa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  lwa_in_if.sink    in_ch,
  lwa_out_if.source out_ch,
  lwa_cfg_if.sink   cfg_ch
);

  lwa_ctl_t ctl;
  lwa_sts_t sts;

  lwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lwa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.reg_index),
    .cfg_data         (cfg_ch.wdata),
    .in_cmd           (in_ch.cmd),
    .in_x_pos         (in_ch.x_pos),
    .in_y_pos         (in_ch.y_pos),
    .in_window_radius (in_ch.window_radius),
    .in_sample_value  (in_ch.sample_value),
    .in_scale_factor  (in_ch.scale_factor),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_average      (out_ch.average),
    .out_window_empty (out_ch.window_empty),
    .ctl              (ctl),
    .sts              (sts)
  );

endmodule

`default_nettype wire

/* tb/tb_lattice_window_average.sv */
`timescale 1ns / 1ps
// tb_lattice_window_average: self-checking bench for the grid store with write,
// scale and edge-clamped window average, using a predictor of its own.
// depends on lwa_pkg, lwa_in_if, lwa_out_if, lwa_cfg_if and lattice_window_average.

module tb_lattice_window_average
  import lwa_pkg::*;
();

  localparam int     CLK_HALF        = 4;
  localparam int     RESET_CYCLES    = 6;
  localparam int     ITEM_GOAL       = 650;
  localparam int     HOLD_OFF_CYCLES = 1500;
  localparam int     REPORT_CAP      = 50;
  localparam longint CYCLE_LIMIT     = 2_000_000;

  // indexes beyond the two grid registers, written to show they change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = REG_IDX_W'(3);

  typedef struct {
    lwa_op_t                  op;
    logic [COORD_W-1:0]       x_pos;
    logic [COORD_W-1:0]       y_pos;
    logic [COORD_W-1:0]       radius;
    logic signed [SAMP_W-1:0] sample;
    logic signed [SAMP_W-1:0] factor;
  } grid_cmd_t;

  typedef struct {
    logic signed [SAMP_W-1:0] average;
    logic                     window_empty;
  } window_result_t;

  logic clk;
  logic rst_n;

  lwa_in_if  in_ch ();
  lwa_out_if out_ch ();
  lwa_cfg_if cfg_ch ();

  lattice_window_average u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // grid model
  logic signed [SAMP_W-1:0] amp_grid [STORE_DEPTH];
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  window_result_t           expected_averages [$];

  int     mismatches  = 0;
  int     items_sent  = 0;
  int     hold_len    = 0;
  int     stall_pct   = 0;
  int     gap_max     = 0;
  int     burst_max   = 1;
  int     burst_left  = 0;
  longint cycle_count = 0;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < REPORT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic int rows_in_use();
    return (rows_reg > MAX_WIDTH) ? MAX_WIDTH : int'(rows_reg);
  endfunction

  function automatic int cols_in_use();
    return (cols_reg > MAX_LENGTH) ? MAX_LENGTH : int'(cols_reg);
  endfunction

  function automatic logic signed [SAMP_W-1:0] scaled_amplitude(
    input logic signed [SAMP_W-1:0] v,
    input logic signed [SAMP_W-1:0] f
  );
    int prod;
    prod = int'(v) * int'(f);
    prod = prod >>> FRAC_BITS;   // floor
    if (prod > 32767) begin
      return 16'sh7fff;
    end
    if (prod < -32768) begin
      return 16'sh8000;
    end
    return SAMP_W'(prod);
  endfunction

  // updates the grid model; returns 0 for a no-op or an off-grid write, else 1
  function automatic bit predict_grid_command(input grid_cmd_t c);
    int             w;
    int             l;
    int             cx;
    int             cy;
    int             cr;
    int             lo_x;
    int             hi_x;
    int             lo_y;
    int             hi_y;
    longint         acc;
    longint         cnt;
    window_result_t res;
    bit             acted;
    w     = rows_in_use();
    l     = cols_in_use();
    cx    = int'(c.x_pos);
    cy    = int'(c.y_pos);
    cr    = int'(c.radius);
    acted = 1'b1;
    case (c.op)
      OP_WRITE: begin
        if (cx < w && cy < l) begin
          amp_grid[cx * l + cy] = c.sample;
        end else begin
          acted = 1'b0;
        end
      end
      OP_SCALE: begin
        if (c.factor != SCALE_ONE) begin
          for (int i = 0; i < w * l; i++) begin
            amp_grid[i] = scaled_amplitude(amp_grid[i], c.factor);
          end
        end
      end
      OP_QUERY: begin
        res.average      = '0;
        res.window_empty = 1'b1;
        if (w != 0 && l != 0) begin
          lo_x = (cx - cr < 0) ? 0 : cx - cr;
          hi_x = (cx + cr > w - 1) ? w - 1 : cx + cr;
          lo_y = (cy - cr < 0) ? 0 : cy - cr;
          hi_y = (cy + cr > l - 1) ? l - 1 : cy + cr;
          if (lo_x <= hi_x && lo_y <= hi_y) begin
            acc = 0;
            for (int i = lo_x; i <= hi_x; i++) begin
              for (int j = lo_y; j <= hi_y; j++) begin
                acc += amp_grid[i * l + j];
              end
            end
            cnt = longint'(hi_x - lo_x + 1) * longint'(hi_y - lo_y + 1);
            res.average      = SAMP_W'(acc / cnt);   // truncates toward zero
            res.window_empty = 1'b0;
          end
        end
        expected_averages.push_back(res);
      end
      default: begin
        acted = 1'b0;
      end
    endcase
    return acted;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_averages.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: average %0d empty %0b",
                                out_ch.average, out_ch.window_empty));
      end else begin
        want = expected_averages.pop_front();
        if (out_ch.average !== want.average) begin
          flag_mismatch($sformatf("average %0d, expected %0d", out_ch.average,
                                  want.average));
        end
        if (out_ch.window_empty !== want.window_empty) begin
          flag_mismatch($sformatf("window_empty %0b, expected %0b",
                                  out_ch.window_empty, want.window_empty));
        end
      end
    end
    if (hold_len > 0) begin
      out_ch.ready <= 1'b0;
      hold_len     <= hold_len - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic grid_cmd_t random_cmd();
    grid_cmd_t c;
    c.op     = OP_NOP;
    c.x_pos  = COORD_W'($urandom);
    c.y_pos  = COORD_W'($urandom);
    c.radius = COORD_W'($urandom);
    c.sample = SAMP_W'($urandom);
    c.factor = SAMP_W'($urandom);
    return c;
  endfunction

  // one input transaction, sent in bursts with random gaps in between
  task automatic issue(input grid_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= c.op;
    in_ch.x_pos         <= c.x_pos;
    in_ch.y_pos         <= c.y_pos;
    in_ch.window_radius <= c.radius;
    in_ch.sample_value  <= c.sample;
    in_ch.scale_factor  <= c.factor;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_grid_command(c)) begin
      items_sent++;
    end
  endtask

  task automatic put_sample(input int x, input int y, input int v);
    grid_cmd_t c;
    c        = random_cmd();
    c.op     = OP_WRITE;
    c.x_pos  = COORD_W'(x);
    c.y_pos  = COORD_W'(y);
    c.sample = SAMP_W'(v);
    issue(c);
  endtask

  task automatic ask_window(input int x, input int y, input int r);
    grid_cmd_t c;
    c        = random_cmd();
    c.op     = OP_QUERY;
    c.x_pos  = COORD_W'(x);
    c.y_pos  = COORD_W'(y);
    c.radius = COORD_W'(r);
    issue(c);
  endtask

  task automatic scale_grid(input int f);
    grid_cmd_t c;
    c        = random_cmd();
    c.op     = OP_SCALE;
    c.factor = SAMP_W'(f);
    issue(c);
  endtask

  task automatic skip_cmd();
    grid_cmd_t c;
    c    = random_cmd();
    c.op = OP_NOP;
    issue(c);
  endtask

  // drain results, then let a scale in flight finish
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (3 * rows_in_use() * cols_in_use() + 64) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:  rows_reg = value;
      REG_GRID_LENGTH: cols_reg = value;
      default: ;
    endcase
  endtask

  // new grid size, then every entry in use gets written so reads stay defined
  task automatic set_grid(input int w, input int l);
    quiesce();
    write_register(REG_GRID_WIDTH, DIM_W'(w));
    write_register(REG_GRID_LENGTH, DIM_W'(l));
    for (int x = 0; x < rows_in_use(); x++) begin
      for (int y = 0; y < cols_in_use(); y++) begin
        put_sample(x, y, int'($urandom_range(0, 65535)));
      end
    end
  endtask

  function automatic int pick_coord(input int limit);
    if (limit > 0 && $urandom_range(0, 9) < 8) begin
      return $urandom_range(0, (limit > 64 ? 64 : limit) - 1);
    end
    return $urandom_range(0, 63);
  endfunction

  task automatic test_empty_grid();
    ask_window(10, 10, 3);
    put_sample(0, 0, 123);
    scale_grid(512);
    skip_cmd();
    quiesce();
    write_register(REG_GRID_WIDTH, DIM_W'(5));
    write_register(REG_SPARE_2, DIM_W'(127));
    write_register(REG_SPARE_3, DIM_W'(85));
    ask_window(0, 0, 63);
    put_sample(1, 0, 77);
  endtask

  task automatic test_clamped_windows();
    set_grid(4, 5);
    ask_window(0, 0, 0);
    ask_window(3, 4, 0);
    ask_window(2, 2, 63);
    ask_window(63, 63, 0);   // centre far outside, nothing left
    ask_window(10, 2, 7);    // centre outside, window reaches last row
    ask_window(2, 63, 58);   // column range clamps to empty
    put_sample(4, 0, 1);
    put_sample(0, 5, 1);
    put_sample(0, 0, 32767);
    put_sample(0, 1, -32768);
    ask_window(0, 0, 1);
    skip_cmd();
  endtask

  task automatic test_scale_extremes();
    scale_grid(int'(SCALE_ONE));
    ask_window(1, 2, 63);
    put_sample(1, 1, 32767);
    put_sample(2, 2, -32768);
    scale_grid(32767);
    ask_window(1, 1, 1);
    scale_grid(-32768);
    ask_window(0, 0, 1);
    scale_grid(0);
    ask_window(2, 2, 63);
  endtask

  task automatic test_wide_grids();
    set_grid(127, 2);
    ask_window(63, 1, 0);
    ask_window(63, 0, 63);
    put_sample(63, 1, -1);
    ask_window(40, 1, 2);
    set_grid(1, 64);
    ask_window(0, 63, 0);
    ask_window(0, 0, 63);
    ask_window(0, 32, 5);
    set_grid(2, 100);
    ask_window(1, 63, 1);
  endtask

  task automatic test_output_backpressure();
    set_grid(6, 6);
    stall_pct = 0;
    gap_max   = 0;
    burst_max = 1;
    hold_len  = HOLD_OFF_CYCLES;
    // results pile up behind the held output until the input stalls
    repeat (8) ask_window(pick_coord(6), pick_coord(6), $urandom_range(0, 3));
    quiesce();
    repeat (4) ask_window(pick_coord(6), pick_coord(6), $urandom_range(0, 6));
  endtask

  task automatic test_random_traffic();
    int sel;
    int w;
    int l;
    int n;
    int f;
    while (items_sent < ITEM_GOAL) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = 0;
        l = $urandom_range(0, 127);
        if ($urandom_range(0, 1) == 1) begin
          w = l;
          l = 0;
        end
      end else if (sel == 1) begin
        w = $urandom_range(64, 127);
        l = $urandom_range(1, 2);
      end else if (sel == 2) begin
        w = $urandom_range(1, 2);
        l = $urandom_range(64, 127);
      end else begin
        w = $urandom_range(1, 8);
        l = $urandom_range(1, 8);
      end
      set_grid(w, l);
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 2;
        default: gap_max = 8;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 60;
      endcase
      burst_max = $urandom_range(1, 12);
      w = rows_in_use();
      l = cols_in_use();
      n = $urandom_range(20, 50);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          put_sample(pick_coord(w), pick_coord(l), int'($urandom_range(0, 65535)));
        end else if (sel < 72) begin
          ask_window(pick_coord(w + 2), pick_coord(l + 2),
                     ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 63));
        end else if (sel < 85) begin
          case ($urandom_range(0, 3))
            0:       f = int'(SCALE_ONE);
            1:       f = $urandom_range(128, 384);
            2:       f = -int'($urandom_range(1, 512));
            default: f = int'($urandom_range(0, 65535));
          endcase
          scale_grid(f);
        end else begin
          skip_cmd();
        end
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = OP_NOP;
    in_ch.x_pos         = '0;
    in_ch.y_pos         = '0;
    in_ch.window_radius = '0;
    in_ch.sample_value  = '0;
    in_ch.scale_factor  = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.reg_index    = REG_GRID_WIDTH;
    cfg_ch.wdata        = '0;
    out_ch.ready        = 1'b0;
    rows_reg            = '0;
    cols_reg            = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      amp_grid[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_max   = 3;
    burst_max = 4;
    stall_pct = 20;
    test_empty_grid();
    test_clamped_windows();
    test_scale_extremes();
    test_wide_grids();
    test_output_backpressure();
    test_random_traffic();
    quiesce();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
